/* design/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define NTC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never holds on a rising clk edge outside reset.
`define NTC_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

/* design/ntc_pkg.sv */
package ntc_pkg;

	// action codes of an input word
	localparam logic [1:0] ACT_LOAD    = 2'd0;
	localparam logic [1:0] ACT_EMIT    = 2'd1;
	localparam logic [1:0] ACT_RESTART = 2'd2;

	// register indexes on the configuration port
	localparam logic [1:0] REG_WIDTH     = 2'd0;
	localparam logic [1:0] REG_HEIGHT    = 2'd1;
	localparam logic [1:0] REG_THRESHOLD = 2'd2;
	localparam logic [1:0] REG_SOURCE    = 2'd3;

	localparam logic [6:0] RST_WIDTH     = 7'd64;
	localparam logic [6:0] RST_HEIGHT    = 7'd64;
	localparam logic [4:0] RST_THRESHOLD = 5'd8;
	localparam logic       RST_SOURCE    = 1'b0;

	localparam logic [7:0] CODE_SOLID = 8'hFF;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] mask_char;
	} ntc_cmd_t;

	typedef struct packed {
		logic [5:0] code_index;
		logic       last_pixel;
	} ntc_result_t;

	typedef struct packed {
		logic [6:0] image_width;
		logic [6:0] image_height;
		logic [4:0] threshold;
		logic       mask_source;
	} ntc_cfg_t;

	typedef logic [5:0] rank_table_t [256];

	// a corner bit may only stand with both of its edges clear, except in the solid code
	function automatic logic code_valid(logic [7:0] c);
		logic bad;
		bad = (c[4] && (c[0] || c[1])) || (c[5] && (c[0] || c[2])) ||
			(c[6] && (c[1] || c[3])) || (c[7] && (c[2] || c[3]));
		return (c == CODE_SOLID) || !bad;
	endfunction

	function automatic rank_table_t build_rank();
		rank_table_t t;
		int          r;
		r = 0;
		for (int i = 0; i < 256; i++) begin
			t[i] = 6'(r);
			if (code_valid(8'(i))) begin
				r++;
			end
		end
		return t;
	endfunction

	localparam rank_table_t RANK_TABLE = build_rank();

endpackage

/* design/wrapped_neighborhood_tile_code_top.sv */
// Load and restart words never raise busy.
// An emit word reads its nine neighbor cells one per cycle from the mask RAM; when
// mask_source is set, bit 2 of column XOR bit 2 of row replaces the RAM data. done pulses
// when busy drops, and a new word is accepted from that cycle on. A walk position outside
// the current image size first goes through modulo reduction. The result is never held off;
// done lasts one cycle. Reset clears registers and pointers; the mask RAM is not cleared.
`include "assert_macros.svh"

module wrapped_neighborhood_tile_code_top #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  ntc_pkg::ntc_cmd_t    cmd,
	output logic                 done,
	output ntc_pkg::ntc_result_t result,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [3:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	import ntc_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int RW    = $clog2(MAX_HEIGHT);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int STEPS = (CW > RW) ? CW : RW;
	localparam int SCW   = $clog2(STEPS);
	localparam int PW    = RW + WW;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_SETUP,
		ST_READ,
		ST_DRAIN,
		ST_OUT
	} state_t;

	function automatic logic [3:0] hex_value(logic [7:0] ch);
		logic [3:0] v;
		v = 4'd0;
		if (ch >= 8'h30 && ch <= 8'h39) begin
			v = 4'(ch - 8'h30);
		end else if (ch >= 8'h41 && ch <= 8'h46) begin
			v = 4'(ch - 8'h37);
		end else if (ch >= 8'h61 && ch <= 8'h66) begin
			v = 4'(ch - 8'h57);
		end
		return v;
	endfunction

	ntc_cfg_t cfg;

	state_t          state_q;
	logic [AW-1:0]   load_ptr_q;
	logic [CW-1:0]   emit_col_q;
	logic [RW-1:0]   emit_row_q;
	logic [CW-1:0]   x_q, xl_q, xr_q;
	logic [RW-1:0]   y_q, yu_q, yd_q;
	logic [WW-1:0]   rem_c_q;
	logic [HW-1:0]   rem_r_q;
	logic [STEPS-1:0] sh_c_q, sh_r_q;
	logic [SCW-1:0]  step_q;
	logic [3:0]      k_q, k_s1;
	logic            v_s1, chk_s1;
	logic [8:0]      nb_q;
	logic            done_q;
	ntc_result_t     result_q;

	logic [WW-1:0]   w_eff;
	logic [HW-1:0]   h_eff;
	logic            accept, ram_we, ram_re;
	logic [AW-1:0]   raddr;
	logic [3:0]      rdata, wdata;
	logic [CW-1:0]   rx;
	logic [RW-1:0]   ry;
	logic [CW+2:0]   rx_ext;
	logic [RW+2:0]   ry_ext;
	logic [PW-1:0]   row_base;
	logic [WW:0]     trial_c;
	logic [HW:0]     trial_r;
	logic [WW-1:0]   rem_c_nx, x_ext;
	logic [HW-1:0]   rem_r_nx, y_ext;
	logic            in_range, cell_set;
	logic [7:0]      code;
	logic            n_b, w_b, e_b, s_b;

	ntc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ntc_ram #(
		.WIDTH (4),
		.DEPTH (DEPTH)
	) u_mask_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (load_ptr_q),
		.wdata (wdata),
		.re    (ram_re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// size registers clamp to 1..MAX
	always_comb begin
		if (cfg.image_width == 7'd0) begin
			w_eff = WW'(1);
		end else if (32'(cfg.image_width) > 32'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(cfg.image_width);
		end
		if (cfg.image_height == 7'd0) begin
			h_eff = HW'(1);
		end else if (32'(cfg.image_height) > 32'(MAX_HEIGHT)) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(cfg.image_height);
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign ram_we = accept && (cmd.action == ACT_LOAD);
	assign wdata  = hex_value(cmd.mask_char);
	assign ram_re = (state_q == ST_READ);

	assign in_range = (32'(emit_col_q) < 32'(w_eff)) && (32'(emit_row_q) < 32'(h_eff));

	// one restoring step of col % width and row % height
	assign trial_c  = {rem_c_q, sh_c_q[STEPS-1]};
	assign trial_r  = {rem_r_q, sh_r_q[STEPS-1]};
	assign rem_c_nx = (trial_c >= {1'b0, w_eff}) ? WW'(trial_c - {1'b0, w_eff}) : WW'(trial_c);
	assign rem_r_nx = (trial_r >= {1'b0, h_eff}) ? HW'(trial_r - {1'b0, h_eff}) : HW'(trial_r);

	assign x_ext = WW'(x_q);
	assign y_ext = HW'(y_q);

	// neighbor k: row k/3 of (up, center, down), column k%3 of (left, center, right)
	always_comb begin
		unique case (k_q)
			4'd0, 4'd3, 4'd6: rx = xl_q;
			4'd2, 4'd5, 4'd8: rx = xr_q;
			default:          rx = x_q;
		endcase
		unique case (k_q)
			4'd0, 4'd1, 4'd2: ry = yu_q;
			4'd6, 4'd7, 4'd8: ry = yd_q;
			default:          ry = y_q;
		endcase
	end

	assign rx_ext   = (CW + 3)'(rx);
	assign ry_ext   = (RW + 3)'(ry);
	assign row_base = PW'(ry) * PW'(w_eff);
	assign raddr    = AW'(row_base + PW'(rx));

	assign cell_set = cfg.mask_source ? chk_s1 : ({1'b0, rdata} >= cfg.threshold);

	assign n_b = nb_q[1];
	assign w_b = nb_q[3];
	assign e_b = nb_q[5];
	assign s_b = nb_q[7];

	always_comb begin
		if (nb_q[4]) begin
			code = CODE_SOLID;
		end else begin
			code = {
				!e_b && !s_b && nb_q[8],
				!w_b && !s_b && nb_q[6],
				!n_b && !e_b && nb_q[2],
				!n_b && !w_b && nb_q[0],
				s_b, e_b, w_b, n_b
			};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			load_ptr_q <= '0;
			emit_col_q <= '0;
			emit_row_q <= '0;
			x_q        <= '0;
			y_q        <= '0;
			xl_q       <= '0;
			xr_q       <= '0;
			yu_q       <= '0;
			yd_q       <= '0;
			rem_c_q    <= '0;
			rem_r_q    <= '0;
			sh_c_q     <= '0;
			sh_r_q     <= '0;
			step_q     <= '0;
			k_q        <= '0;
			k_s1       <= '0;
			v_s1       <= 1'b0;
			chk_s1     <= 1'b0;
			nb_q       <= '0;
			done_q     <= 1'b0;
			result_q   <= '0;
		end else begin
			done_q <= 1'b0;
			v_s1   <= ram_re;
			k_s1   <= k_q;
			chk_s1 <= rx_ext[2] ^ ry_ext[2];
			if (v_s1) begin
				nb_q[k_s1] <= cell_set;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (cmd.action)
							ACT_LOAD: begin
								load_ptr_q <= (load_ptr_q == AW'(DEPTH - 1)) ? '0 : load_ptr_q + 1'b1;
							end
							ACT_RESTART: begin
								load_ptr_q <= '0;
								emit_col_q <= '0;
								emit_row_q <= '0;
							end
							ACT_EMIT: begin
								if (in_range) begin
									x_q     <= emit_col_q;
									y_q     <= emit_row_q;
									state_q <= ST_SETUP;
								end else begin
									rem_c_q <= '0;
									rem_r_q <= '0;
									sh_c_q  <= STEPS'(emit_col_q);
									sh_r_q  <= STEPS'(emit_row_q);
									step_q  <= '0;
									state_q <= ST_REDUCE;
								end
							end
							default: ;
						endcase
					end
				end
				ST_REDUCE: begin
					rem_c_q <= rem_c_nx;
					rem_r_q <= rem_r_nx;
					sh_c_q  <= sh_c_q << 1;
					sh_r_q  <= sh_r_q << 1;
					step_q  <= step_q + 1'b1;
					if (step_q == SCW'(STEPS - 1)) begin
						x_q     <= CW'(rem_c_nx);
						y_q     <= RW'(rem_r_nx);
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					xl_q    <= (x_q == '0) ? CW'(w_eff - 1'b1) : x_q - 1'b1;
					xr_q    <= (x_ext + 1'b1 == w_eff) ? '0 : CW'(x_ext + 1'b1);
					yu_q    <= (y_q == '0) ? RW'(h_eff - 1'b1) : y_q - 1'b1;
					yd_q    <= (y_ext + 1'b1 == h_eff) ? '0 : RW'(y_ext + 1'b1);
					k_q     <= '0;
					state_q <= ST_READ;
				end
				ST_READ: begin
					k_q <= k_q + 1'b1;
					if (k_q == 4'd8) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					done_q              <= 1'b1;
					result_q.code_index <= RANK_TABLE[code];
					result_q.last_pixel <= (x_ext == w_eff - 1'b1) && (y_ext == h_eff - 1'b1);
					// advance the raster walk, wrapping at the image end
					if (x_ext + 1'b1 == w_eff) begin
						emit_col_q <= '0;
						emit_row_q <= (y_ext + 1'b1 == h_eff) ? '0 : RW'(y_ext + 1'b1);
					end else begin
						emit_col_q <= CW'(x_ext + 1'b1);
						emit_row_q <= y_q;
					end
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign done   = done_q;
	assign result = result_q;

	`NTC_ASSERT(a_done_not_busy, done |-> !busy, "result strobe while still busy")
	`NTC_ASSERT(a_rank_range, done |-> (result.code_index <= 6'd47), "code rank above 47")
	`NTC_ASSERT(a_emit_busy, (start && !busy && cmd.action == ACT_EMIT) |=> busy,
		"emit word did not start the sequencer")
	`NTC_NEVER(a_write_idle, ram_we && (state_q != ST_IDLE), "mask write during neighbor reads")

endmodule

/* design/ntc_ram.sv */
module ntc_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* design/ntc_cfg.sv */
module ntc_cfg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [3:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	output ntc_pkg::ntc_cfg_t cfg
);

	import ntc_pkg::*;

	ntc_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width  <= RST_WIDTH;
			cfg_q.image_height <= RST_HEIGHT;
			cfg_q.threshold    <= RST_THRESHOLD;
			cfg_q.mask_source  <= RST_SOURCE;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_WIDTH:     cfg_q.image_width  <= pwdata[6:0];
				REG_HEIGHT:    cfg_q.image_height <= pwdata[6:0];
				REG_THRESHOLD: cfg_q.threshold    <= pwdata[4:0];
				REG_SOURCE:    cfg_q.mask_source  <= pwdata[0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_WIDTH:     prdata = 32'(cfg_q.image_width);
			REG_HEIGHT:    prdata = 32'(cfg_q.image_height);
			REG_THRESHOLD: prdata = 32'(cfg_q.threshold);
			REG_SOURCE:    prdata = 32'(cfg_q.mask_source);
		endcase
	end

	assign pready = 1'b1;
	assign cfg    = cfg_q;

endmodule
